@@ src/abfi_pkg.sv @@
// Shared constants, types and helper functions for the box-fold iteration block.
`default_nettype none

package abfi_pkg;

    // Value format: signed Q8.24 points, scales and offsets
    localparam int VW = 32;
    localparam int FB = 24;
    // Derivative format: unsigned Q16.16
    localparam int DE_W = 32;
    localparam int DE_FB = 16;

    // Divisor width, enough to hold 1.0
    localparam int DW = FB + 1;
    // Product widths and divider numerator width
    localparam int PW = 2 * VW;
    localparam int DPW = DE_W + VW;
    localparam int NW = (DPW > PW) ? DPW : PW;
    // Width of the wide signed values ahead of saturation
    localparam int SW = NW + 4;
    // Width of the truncated squared radius
    localparam int RQW = PW + 2 - FB;
    // Divider lanes: x, y, z and the derivative
    localparam int LANES = 4;
    localparam int LANE_DE = 3;

    // Stream payload widths, rounded up to whole bytes
    localparam int IN_BITS = 7 * VW + DE_W;
    localparam int IN_TW = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 4 * VW + DE_W;
    localparam int OUT_TW = ((OUT_BITS + 7) / 8) * 8;

    localparam int CFG_IW = 3;

    // Fixed-point constants
    localparam logic [DW-1:0] ONE_D = {1'b1, {FB{1'b0}}};
    localparam logic [VW:0] ONE_V1 = {{(VW - FB){1'b0}}, 1'b1, {FB{1'b0}}};
    localparam logic [NW:0] DE_ONE = {{(NW - DE_FB){1'b0}}, 1'b1, {DE_FB{1'b0}}};
    localparam logic [NW:0] DE_MAX = {{(NW + 1 - DE_W){1'b0}}, {DE_W{1'b1}}};
    localparam logic signed [SW-1:0] VMAX_W = signed'({{(SW - VW + 1){1'b0}}, {(VW - 1){1'b1}}});
    localparam logic signed [SW-1:0] VMIN_W = signed'({{(SW - VW + 1){1'b1}}, {(VW - 1){1'b0}}});

    // Configuration register indexes
    typedef enum logic [CFG_IW-1:0] {
        REG_BASE_SCALE      = 3'd0,
        REG_SCALE_VARIATION = 3'd1,
        REG_FOLD_LIMIT      = 3'd2,
        REG_FOLD_OFFSET_X   = 3'd3,
        REG_FOLD_OFFSET_Y   = 3'd4,
        REG_FOLD_OFFSET_Z   = 3'd5,
        REG_MIN_RADIUS_SQ   = 3'd6,
        REG_FOLD_Z_ENABLE   = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [VW-1:0] base_scale;
        logic [VW-1:0] scale_variation;
        logic [VW-2:0] fold_limit;
        logic [VW-1:0] fold_offset_x;
        logic [VW-1:0] fold_offset_y;
        logic [VW-1:0] fold_offset_z;
        logic [DW-1:0] min_radius_sq;
        logic          fold_z_enable;
    } cfg_t;

    // Folded point and varied scale leaving the front end
    typedef struct packed {
        logic [VW-1:0]   fx;
        logic [VW-1:0]   fy;
        logic [VW-1:0]   fz;
        logic [VW-1:0]   s;
        logic [DE_W-1:0] de;
        logic [VW-1:0]   cx;
        logic [VW-1:0]   cy;
        logic [VW-1:0]   cz;
        logic            ov;
    } front_t;

    // Data riding alongside the divider
    typedef struct packed {
        logic [VW-1:0] s;
        logic [VW-1:0] cx;
        logic [VW-1:0] cy;
        logic [VW-1:0] cz;
        logic [2:0]    neg;
        logic          ov;
    } side_t;

    // Saturate a wide signed value; returns {overflow, value}
    function automatic logic [VW:0] sat_v(input logic signed [SW-1:0] v);
        logic [VW:0] r;
        if (v > VMAX_W) begin
            r = {1'b1, VMAX_W[VW-1:0]};
        end
        else if (v < VMIN_W) begin
            r = {1'b1, VMIN_W[VW-1:0]};
        end
        else begin
            r = {1'b0, v[VW-1:0]};
        end
        return r;
    endfunction

    // Sign-extend a value to the wide width
    function automatic logic signed [SW-1:0] sext_w(input logic [VW-1:0] v);
        return signed'({{(SW - VW){v[VW-1]}}, v});
    endfunction

    // Magnitude of a signed value as unsigned of the same width
    function automatic logic [VW-1:0] mag_v(input logic [VW-1:0] v);
        return v[VW-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

`default_nettype wire

@@ src/amazing_box_fold_iteration_top.sv @@
// Top level of the box-fold iteration pipeline: streams, config and output stages.
//
//  Channel   Direction  Transaction
//  s_*       in         in_x, in_y, in_z, c_x, c_y, c_z, de_in, scale_in
//  m_*       out        out_x, out_y, out_z, de_out, scale_out; overflow_flag in tuser
//  cfg_*     in         register index and write data, always ready
//
//  One point enters every cycle while the output is not stalled.
//  The divider, one quotient bit per stage over the 64-bit products, sets the depth.
//  Reset clears the valid bits and loads the register defaults.
//  A stalled output freezes every stage together; s_tready drops while the stall lasts.
`default_nettype none

module amazing_box_fold_iteration_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // in_x, in_y, in_z, c_x, c_y, c_z, de_in, scale_in (lowest first)
    input  wire logic [abfi_pkg::IN_TW-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // out_x, out_y, out_z, de_out, scale_out (lowest first)
    output logic [abfi_pkg::OUT_TW-1:0]         m_tdata,
    // overflow_flag
    output logic                                m_tuser,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [abfi_pkg::CFG_IW-1:0]    cfg_index,
    input  wire logic [abfi_pkg::VW-1:0]        cfg_data
);

    localparam int VW = abfi_pkg::VW;
    localparam int NW = abfi_pkg::NW;
    localparam int DE_W = abfi_pkg::DE_W;
    localparam int LANES = abfi_pkg::LANES;

    logic ce;
    abfi_pkg::cfg_t cfg;

    logic front_valid, mul_valid, div_valid;
    abfi_pkg::front_t front_out;
    logic [LANES-1:0][NW-1:0] mul_num, quo;
    logic [abfi_pkg::DW-1:0] mul_den;
    abfi_pkg::side_t mul_side, div_side, side_b1_reg;

    logic                  b1_vld_reg;
    logic [NW:0]           qs_reg [3];
    logic [NW:0]           des_reg;

    logic                  m_valid_reg;
    logic [abfi_pkg::OUT_TW-1:0] m_data_reg, m_data_next;
    logic                  m_user_reg, m_user_next;

    // Stall every stage while the output holds an untaken transaction
    assign ce        = !m_valid_reg || m_tready;
    assign s_tready  = ce;
    assign cfg_ready = 1'b1;

    abfi_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    abfi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .cfg       (cfg),
        .out_valid (front_valid),
        .out       (front_out)
    );

    abfi_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (front_valid),
        .in        (front_out),
        .cfg       (cfg),
        .out_valid (mul_valid),
        .num       (mul_num),
        .den       (mul_den),
        .side      (mul_side)
    );

    abfi_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (mul_valid),
        .num       (mul_num),
        .den       (mul_den),
        .side_in   (mul_side),
        .out_valid (div_valid),
        .quo       (quo),
        .side_out  (div_side)
    );

    // Apply signs to the quotients and add one to the derivative
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
            begin
                qs_reg[i] <= div_side.neg[i] ? ((NW+1)'(0) - {1'b0, quo[i]}) : {1'b0, quo[i]};
            end
            des_reg     <= {1'b0, quo[abfi_pkg::LANE_DE]} + abfi_pkg::DE_ONE;
            side_b1_reg <= div_side;
        end
    end

    logic signed [abfi_pkg::SW-1:0] ox_w, oy_w, oz_w;
    logic [VW:0] satx, saty, satz;
    logic        de_sat;
    logic [DE_W-1:0] de_val;

    // Add c with x and y swapped, then saturate
    always_comb
    begin
        ox_w = signed'({{3{qs_reg[0][NW]}}, qs_reg[0]}) + abfi_pkg::sext_w(side_b1_reg.cy);
        oy_w = signed'({{3{qs_reg[1][NW]}}, qs_reg[1]}) + abfi_pkg::sext_w(side_b1_reg.cx);
        oz_w = signed'({{3{qs_reg[2][NW]}}, qs_reg[2]}) + abfi_pkg::sext_w(side_b1_reg.cz);
        satx = abfi_pkg::sat_v(ox_w);
        saty = abfi_pkg::sat_v(oy_w);
        satz = abfi_pkg::sat_v(oz_w);
        de_sat = des_reg > abfi_pkg::DE_MAX;
        de_val = de_sat ? {DE_W{1'b1}} : des_reg[DE_W-1:0];
        m_data_next = abfi_pkg::OUT_TW'({side_b1_reg.s, de_val, satz[VW-1:0],
                                         saty[VW-1:0], satx[VW-1:0]});
        m_user_next = side_b1_reg.ov | satx[VW] | saty[VW] | satz[VW] | de_sat;
    end

    // Valid bits for the last two stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            b1_vld_reg  <= div_valid;
            m_valid_reg <= b1_vld_reg;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

@@ src/abfi_cfg.sv @@
// Configuration register file written through its own valid/ready channel.
`default_nettype none

module abfi_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [abfi_pkg::CFG_IW-1:0]   wr_index,
    input  wire logic [abfi_pkg::VW-1:0]       wr_data,
    output abfi_pkg::cfg_t                     cfg
);

    abfi_pkg::cfg_t cfg_reg;
    abfi_pkg::cfg_t cfg_next;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (abfi_pkg::cfg_reg_t'(wr_index))
                abfi_pkg::REG_BASE_SCALE:      cfg_next.base_scale = wr_data;
                abfi_pkg::REG_SCALE_VARIATION: cfg_next.scale_variation = wr_data;
                abfi_pkg::REG_FOLD_LIMIT:      cfg_next.fold_limit = wr_data[abfi_pkg::VW-2:0];
                abfi_pkg::REG_FOLD_OFFSET_X:   cfg_next.fold_offset_x = wr_data;
                abfi_pkg::REG_FOLD_OFFSET_Y:   cfg_next.fold_offset_y = wr_data;
                abfi_pkg::REG_FOLD_OFFSET_Z:   cfg_next.fold_offset_z = wr_data;
                abfi_pkg::REG_MIN_RADIUS_SQ:
                    cfg_next.min_radius_sq = wr_data[abfi_pkg::DW-1:0];
                abfi_pkg::REG_FOLD_Z_ENABLE:   cfg_next.fold_z_enable = wr_data[0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers; reset to -2.0 scale, 1.0 limit, 0.25 min radius
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_scale <= {{(abfi_pkg::VW - abfi_pkg::FB - 1){1'b1}}, 1'b0,
                                   {abfi_pkg::FB{1'b0}}};
            cfg_reg.scale_variation <= '0;
            cfg_reg.fold_limit <= {{(abfi_pkg::VW - 2 - abfi_pkg::FB){1'b0}}, 1'b1,
                                   {abfi_pkg::FB{1'b0}}};
            cfg_reg.fold_offset_x <= '0;
            cfg_reg.fold_offset_y <= '0;
            cfg_reg.fold_offset_z <= '0;
            cfg_reg.min_radius_sq <= {3'b001, {(abfi_pkg::FB - 2){1'b0}}};
            cfg_reg.fold_z_enable <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ src/abfi_front.sv @@
// Front end: box fold of each axis and scale variation, three stages.
`default_nettype none

module abfi_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        ce,
    input  wire logic                        in_valid,
    input  wire logic [abfi_pkg::IN_TW-1:0]  in_data,
    input  wire abfi_pkg::cfg_t              cfg,
    output logic                             out_valid,
    output abfi_pkg::front_t                 out
);

    localparam int VW = abfi_pkg::VW;
    localparam int FB = abfi_pkg::FB;
    localparam int PW = abfi_pkg::PW;
    localparam int SW = abfi_pkg::SW;
    localparam int DE_W = abfi_pkg::DE_W;

    // |v + off| without overflow
    function automatic logic [VW:0] abs_sum(input logic [VW-1:0] v, input logic [VW-1:0] off);
        logic [VW:0] s;
        s = {v[VW-1], v} + {off[VW-1], off};
        return s[VW] ? (~s + 1'b1) : s;
    endfunction

    logic [2:0] vld_reg;

    // Stage 1 registers
    logic [VW:0]     ax_reg, ay_reg, az_reg;
    logic [VW-1:0]   tmag_reg;
    logic            tneg_reg;
    logic [VW-1:0]   pz1_reg, cx1_reg, cy1_reg, cz1_reg;
    logic [DE_W-1:0] de1_reg;
    // Stage 2 registers
    logic [VW:0]     bx_reg, by_reg, bz_reg;
    logic [PW-1:0]   prod_reg;
    logic            pneg_reg;
    logic [VW-1:0]   pz2_reg, cx2_reg, cy2_reg, cz2_reg;
    logic [DE_W-1:0] de2_reg;
    // Stage 3 register
    abfi_pkg::front_t out_reg;

    logic [VW-1:0] px, py, pz, prev, pmag;
    logic [VW:0]   t_next;

    // Unpack the input transaction
    assign px   = in_data[VW-1:0];
    assign py   = in_data[2*VW-1:VW];
    assign pz   = in_data[3*VW-1:2*VW];
    assign pmag = abfi_pkg::mag_v(prev);
    assign prev = in_data[6*VW+DE_W+VW-1:6*VW+DE_W];
    assign t_next = {1'b0, pmag} - abfi_pkg::ONE_V1;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    // Stage 1: offset sums and |prev| - 1
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ax_reg   <= abs_sum(px, cfg.fold_offset_x);
            ay_reg   <= abs_sum(py, cfg.fold_offset_y);
            az_reg   <= abs_sum(pz, cfg.fold_offset_z);
            tneg_reg <= t_next[VW];
            tmag_reg <= t_next[VW] ? VW'(~t_next + 1'b1) : t_next[VW-1:0];
            pz1_reg  <= pz;
            cx1_reg  <= in_data[4*VW-1:3*VW];
            cy1_reg  <= in_data[5*VW-1:4*VW];
            cz1_reg  <= in_data[6*VW-1:5*VW];
            de1_reg  <= in_data[6*VW+DE_W-1:6*VW];
        end
    end

    logic [VW+1:0] dx, dy, dz;
    logic [VW-1:0] svm;

    assign dx  = {1'b0, ax_reg} - {3'b000, cfg.fold_limit};
    assign dy  = {1'b0, ay_reg} - {3'b000, cfg.fold_limit};
    assign dz  = {1'b0, az_reg} - {3'b000, cfg.fold_limit};
    assign svm = abfi_pkg::mag_v(cfg.scale_variation);

    // Stage 2: distance from the limit and the variation product
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            bx_reg   <= dx[VW+1] ? VW'(~dx + 1'b1) + (VW+1)'(0) : dx[VW:0];
            by_reg   <= dy[VW+1] ? VW'(~dy + 1'b1) + (VW+1)'(0) : dy[VW:0];
            bz_reg   <= dz[VW+1] ? VW'(~dz + 1'b1) + (VW+1)'(0) : dz[VW:0];
            prod_reg <= PW'(svm) * PW'(tmag_reg);
            pneg_reg <= cfg.scale_variation[VW-1] ^ tneg_reg;
            pz2_reg  <= pz1_reg;
            cx2_reg  <= cx1_reg;
            cy2_reg  <= cy1_reg;
            cz2_reg  <= cz1_reg;
            de2_reg  <= de1_reg;
        end
    end

    logic signed [SW-1:0] lim_w, fvx, fvy, fvz, qv, sv;
    logic [VW:0] satx, saty, satz, sats;

    // Stage 3 combinational: fold result and varied scale with saturation
    always_comb
    begin
        lim_w = signed'(SW'(cfg.fold_limit));
        fvx = lim_w - signed'(SW'(bx_reg)) - signed'(SW'(abfi_pkg::mag_v(cfg.fold_offset_x)));
        fvy = lim_w - signed'(SW'(by_reg)) - signed'(SW'(abfi_pkg::mag_v(cfg.fold_offset_y)));
        fvz = lim_w - signed'(SW'(bz_reg)) - signed'(SW'(abfi_pkg::mag_v(cfg.fold_offset_z)));
        qv  = signed'(SW'(prod_reg[PW-1:FB]));
        if (pneg_reg)
        begin
            qv = -qv;
        end
        sv   = abfi_pkg::sext_w(cfg.base_scale) + qv;
        satx = abfi_pkg::sat_v(fvx);
        saty = abfi_pkg::sat_v(fvy);
        satz = cfg.fold_z_enable ? abfi_pkg::sat_v(fvz) : {1'b0, pz2_reg};
        sats = abfi_pkg::sat_v(sv);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            out_reg.fx <= satx[VW-1:0];
            out_reg.fy <= saty[VW-1:0];
            out_reg.fz <= satz[VW-1:0];
            out_reg.s  <= sats[VW-1:0];
            out_reg.de <= de2_reg;
            out_reg.cx <= cx2_reg;
            out_reg.cy <= cy2_reg;
            out_reg.cz <= cz2_reg;
            out_reg.ov <= satx[VW] | saty[VW] | satz[VW] | sats[VW];
        end
    end

    assign out_valid = vld_reg[2];
    assign out       = out_reg;

endmodule

`default_nettype wire

@@ src/abfi_mul.sv @@
// Products, squared radius and sphere-fold divisor choice, three stages.
`default_nettype none

module abfi_mul (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         ce,
    input  wire logic                                         in_valid,
    input  wire abfi_pkg::front_t                             in,
    input  wire abfi_pkg::cfg_t                               cfg,
    output logic                                              out_valid,
    output logic [abfi_pkg::LANES-1:0][abfi_pkg::NW-1:0]      num,
    output logic [abfi_pkg::DW-1:0]                           den,
    output abfi_pkg::side_t                                   side
);

    localparam int VW = abfi_pkg::VW;
    localparam int PW = abfi_pkg::PW;
    localparam int DPW = abfi_pkg::DPW;
    localparam int NW = abfi_pkg::NW;
    localparam int DW = abfi_pkg::DW;
    localparam int FB = abfi_pkg::FB;
    localparam int RQW = abfi_pkg::RQW;
    localparam int LANES_T = abfi_pkg::LANES;

    logic [2:0] vld_reg;

    logic [PW-1:0]  sqx_reg, sqy_reg, sqz_reg;
    logic [PW-1:0]  nx1_reg, ny1_reg, nz1_reg, nx2_reg, ny2_reg, nz2_reg;
    logic [DPW-1:0] nde1_reg, nde2_reg;
    abfi_pkg::side_t side1_reg, side2_reg, side3_reg;
    logic [RQW-1:0] rrq_reg;
    logic [LANES_T-1:0][NW-1:0] num_reg;
    logic [DW-1:0]  den_reg;

    logic [VW-1:0] fxm, fym, fzm, sm;
    logic [PW+1:0] rr_next;
    logic [DW-1:0] minr;
    logic [DW-1:0] den_next;

    assign fxm = abfi_pkg::mag_v(in.fx);
    assign fym = abfi_pkg::mag_v(in.fy);
    assign fzm = abfi_pkg::mag_v(in.fz);
    assign sm  = abfi_pkg::mag_v(in.s);

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    // Stage 1: squares and scaled magnitudes
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sqx_reg  <= PW'(fxm) * PW'(fxm);
            sqy_reg  <= PW'(fym) * PW'(fym);
            sqz_reg  <= PW'(fzm) * PW'(fzm);
            nx1_reg  <= PW'(fxm) * PW'(sm);
            ny1_reg  <= PW'(fym) * PW'(sm);
            nz1_reg  <= PW'(fzm) * PW'(sm);
            nde1_reg <= DPW'(in.de) * DPW'(sm);
            side1_reg.s   <= in.s;
            side1_reg.cx  <= in.cx;
            side1_reg.cy  <= in.cy;
            side1_reg.cz  <= in.cz;
            side1_reg.neg <= {in.fz[VW-1] ^ in.s[VW-1], in.fy[VW-1] ^ in.s[VW-1],
                              in.fx[VW-1] ^ in.s[VW-1]};
            side1_reg.ov  <= in.ov;
        end
    end

    assign rr_next = (PW+2)'(sqx_reg) + (PW+2)'(sqy_reg) + (PW+2)'(sqz_reg);

    // Stage 2: squared radius cut to the fraction width
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rrq_reg   <= rr_next[PW+1:FB];
            nx2_reg   <= nx1_reg;
            ny2_reg   <= ny1_reg;
            nz2_reg   <= nz1_reg;
            nde2_reg  <= nde1_reg;
            side2_reg <= side1_reg;
        end
    end

    // Stage 3: pick min radius, radius or one as the divisor
    always_comb
    begin
        minr = (cfg.min_radius_sq == '0) ? DW'(1) : cfg.min_radius_sq;
        if (rrq_reg < RQW'(minr))
        begin
            den_next = minr;
        end
        else if (rrq_reg < RQW'(abfi_pkg::ONE_D))
        begin
            den_next = rrq_reg[DW-1:0];
        end
        else
        begin
            den_next = abfi_pkg::ONE_D;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            den_reg    <= den_next;
            num_reg[0] <= NW'(nx2_reg);
            num_reg[1] <= NW'(ny2_reg);
            num_reg[2] <= NW'(nz2_reg);
            num_reg[abfi_pkg::LANE_DE] <= NW'(nde2_reg);
            side3_reg  <= side2_reg;
        end
    end

    assign out_valid = vld_reg[2];
    assign num       = num_reg;
    assign den       = den_reg;
    assign side      = side3_reg;

endmodule

`default_nettype wire

@@ src/abfi_div.sv @@
// Pipelined restoring divider: one quotient bit per stage for all lanes.
`default_nettype none

module abfi_div (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       ce,
    input  wire logic                                       in_valid,
    input  wire logic [abfi_pkg::LANES-1:0][abfi_pkg::NW-1:0] num,
    input  wire logic [abfi_pkg::DW-1:0]                    den,
    input  wire abfi_pkg::side_t                            side_in,
    output logic                                            out_valid,
    output logic [abfi_pkg::LANES-1:0][abfi_pkg::NW-1:0]    quo,
    output abfi_pkg::side_t                                 side_out
);

    localparam int NW = abfi_pkg::NW;
    localparam int DW = abfi_pkg::DW;
    localparam int LANES = abfi_pkg::LANES;

    logic [NW-1:0]   num_reg [NW][LANES];
    logic [DW-1:0]   rem_reg [NW][LANES];
    logic [DW-1:0]   den_reg [NW];
    abfi_pkg::side_t side_reg [NW];
    logic [NW-1:0]   vld_reg;

    genvar k, l;
    for (k = 0; k < NW; k++)
    begin : g_stage
        logic [NW-1:0]   num_in [LANES];
        logic [DW-1:0]   rem_in [LANES];
        logic [DW-1:0]   den_in;
        abfi_pkg::side_t side_in_k;
        logic            vld_in;
        logic [NW-1:0]   num_next [LANES];
        logic [DW-1:0]   rem_next [LANES];

        // Select the previous stage, or the inputs at the head
        if (k == 0)
        begin : g_head
            for (l = 0; l < LANES; l++)
            begin : g_lane_in
                assign num_in[l] = num[l];
                assign rem_in[l] = '0;
            end
            assign den_in    = den;
            assign side_in_k = side_in;
            assign vld_in    = in_valid;
        end
        else
        begin : g_body
            for (l = 0; l < LANES; l++)
            begin : g_lane_in
                assign num_in[l] = num_reg[k-1][l];
                assign rem_in[l] = rem_reg[k-1][l];
            end
            assign den_in    = den_reg[k-1];
            assign side_in_k = side_reg[k-1];
            assign vld_in    = vld_reg[k-1];
        end

        // Shift in one numerator bit, subtract the divisor where it fits
        for (l = 0; l < LANES; l++)
        begin : g_lane
            logic [DW:0] rs;
            logic        take;
            assign rs   = {rem_in[l], num_in[l][NW-1]};
            assign take = rs >= {1'b0, den_in};
            assign rem_next[l] = take ? DW'(rs - {1'b0, den_in}) : rs[DW-1:0];
            assign num_next[l] = {num_in[l][NW-2:0], take};

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    num_reg[k][l] <= num_next[l];
                    rem_reg[k][l] <= rem_next[l];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in_k;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (ce)
            begin
                vld_reg[k] <= vld_in;
            end
        end
    end

    for (l = 0; l < LANES; l++)
    begin : g_out
        assign quo[l] = num_reg[NW-1][l];
    end

    assign out_valid = vld_reg[NW-1];
    assign side_out  = side_reg[NW-1];

endmodule

`default_nettype wire
